FILE: sv/double_hash_table_insert_assert.svh
`ifndef DOUBLE_HASH_TABLE_INSERT_ASSERT_SVH
`define DOUBLE_HASH_TABLE_INSERT_ASSERT_SVH

// Same-edge implication, off while reset is held.
`define DHT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-edge implication, off while reset is held.
`define DHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/dht_pkg.sv
`timescale 1ns / 1ps
package dht_pkg;

    localparam int MAX_SLOTS   = 1024;
    localparam int ADDR_W      = $clog2(MAX_SLOTS);
    localparam int CNT_W       = $clog2(MAX_SLOTS + 1);
    localparam int SUM_W       = ADDR_W + 1;
    localparam int KEY_W       = 31;
    localparam int CFG_W       = 11;
    localparam int ACC_W       = 32;
    localparam int CFG_RESET   = 1024;
    localparam int ITER_W      = $clog2(KEY_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_PLACED  = 2'd0,
        ST_FULL    = 2'd1,
        ST_DROPPED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV1,
        F_DIV2,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_HOME,
        B_STEP,
        B_CHK
    } t_back_state;

    typedef struct packed {
        logic [ADDR_W-1:0] home;
        logic [ADDR_W-1:0] step;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

    typedef struct packed {
        logic              valid;
        t_status           status;
        logic [ADDR_W-1:0] slot;
        logic [CNT_W-1:0]  probe_count;
        logic [ACC_W-1:0]  access_total;
        logic [CNT_W-1:0]  key_count;
    } t_result;

    // Map the raw register to the slot count in use: zero acts as one,
    // anything past the table acts as the full table.
    function automatic logic [CNT_W-1:0] clamp_size(input logic [CFG_W-1:0] raw);
        int v;
        v = int'(raw);
        if (v == 0) v = 1;
        if (v > MAX_SLOTS) v = MAX_SLOTS;
        return CNT_W'(v);
    endfunction

endpackage

FILE: sv/double_hash_table_insert.sv
`timescale 1ns / 1ps
// Double-hashing insert engine for an open-addressing table of up to MAX_SLOTS slots.
//
// Command channel: drive i_key and raise start; the key transfers at the rising
// edge where start is high and busy is low. Result channel: o_valid pulses for
// one cycle with o_status, o_slot, o_probe_count, o_access_total and o_key_count;
// the receiver cannot hold a result off, so every pulse is a completed transfer.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into table_size at the edge;
// only write while no key is in flight.
//
// Timing: the front end runs a bit-serial divide, one bit per cycle over the 31
// key bits. A key below table_size needs one pass, a larger key a second pass
// for the step. Unless the key count has reached table_size, the back end then
// tests the home slot and then each probe step, one occupancy read each; the step
// that lands back on home makes no read. A two-entry queue lets the divider work
// on the next key while the back end walks.
//
// Reset: synchronous, active low. After reset busy stays high while the occupancy
// store is swept to empty.
module double_hash_table_insert import dht_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [CFG_W-1:0]  i_cfg_wr_data,
    input  logic              start,
    output logic              busy,
    input  logic [KEY_W-1:0]  i_key,
    output logic              o_valid,
    output logic [1:0]        o_status,
    output logic [ADDR_W-1:0] o_slot,
    output logic [CNT_W-1:0]  o_probe_count,
    output logic [ACC_W-1:0]  o_access_total,
    output logic [CNT_W-1:0]  o_key_count
);

    // clamped slot count, kept in its usable form
    logic [CNT_W-1:0] r_size;

    logic     accept;
    logic     front_busy;
    logic     clearing;
    logic     push;
    logic     pop;
    t_job     front_job;
    t_job     head_job;
    t_q_flags q_flags;
    t_result  result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= clamp_size(CFG_W'(CFG_RESET));
        end else if (i_cfg_wr_en) begin
            r_size <= clamp_size(i_cfg_wr_data);
        end
    end

    // hold off keys during reset, the clearing sweep and while the front end divides or waits to push
    assign busy   = !i_rst_n || front_busy || clearing;
    assign accept = start && !busy;

    dht_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_key     (i_key),
        .i_size    (r_size),
        .i_q_flags (q_flags),
        .o_busy    (front_busy),
        .o_push    (push),
        .o_job     (front_job)
    );

    dht_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_flags (q_flags),
        .o_job   (head_job)
    );

    dht_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_size     (r_size),
        .i_q_flags  (q_flags),
        .i_job      (head_job),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_result   (result)
    );

    assign o_valid        = result.valid;
    assign o_status       = result.status;
    assign o_slot         = result.slot;
    assign o_probe_count  = result.probe_count;
    assign o_access_total = result.access_total;
    assign o_key_count    = result.key_count;

endmodule

FILE: sv/dht_front.sv
`timescale 1ns / 1ps
module dht_front import dht_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [KEY_W-1:0] i_key,
    input  logic [CNT_W-1:0] i_size,
    input  t_q_flags         i_q_flags,
    output logic             o_busy,
    output logic             o_push,
    output t_job             o_job
);

    t_front_state      r_state, n_state;
    logic [KEY_W-1:0]  r_dq, n_dq;
    logic [ADDR_W-1:0] r_rem, n_rem;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic [ADDR_W-1:0] r_home, n_home;
    logic [ADDR_W-1:0] r_step, n_step;

    logic [SUM_W-1:0]  shifted;
    logic              take;
    logic [ADDR_W-1:0] rem_next;
    logic [KEY_W-1:0]  dq_next;
    logic              last;

    // One restoring divide step per cycle: dividend shifts out as quotient shifts in.
    always_comb begin
        shifted  = {r_rem, r_dq[KEY_W-1]};
        take     = (shifted >= SUM_W'(i_size));
        rem_next = take ? ADDR_W'(shifted - SUM_W'(i_size)) : ADDR_W'(shifted);
        dq_next  = {r_dq[KEY_W-2:0], take};
        last     = (r_iter == ITER_W'(KEY_W - 1));
    end

    always_comb begin
        n_state = r_state;
        n_dq    = r_dq;
        n_rem   = r_rem;
        n_iter  = r_iter;
        n_home  = r_home;
        n_step  = r_step;
        o_push  = 1'b0;
        case (r_state)
            F_IDLE: begin
                if (i_accept) begin
                    n_dq    = i_key;
                    n_rem   = '0;
                    n_iter  = '0;
                    n_state = F_DIV1;
                end
            end
            F_DIV1: begin
                n_dq   = dq_next;
                n_rem  = rem_next;
                n_iter = r_iter + ITER_W'(1);
                if (last) begin
                    n_home = rem_next;
                    if (dq_next == '0) begin
                        // key below size: unit step
                        n_step  = ADDR_W'(1);
                        n_state = F_PUSH;
                    end else begin
                        // reduce the quotient modulo size for the step
                        n_rem   = '0;
                        n_iter  = '0;
                        n_state = F_DIV2;
                    end
                end
            end
            F_DIV2: begin
                n_dq   = dq_next;
                n_rem  = rem_next;
                n_iter = r_iter + ITER_W'(1);
                if (last) begin
                    n_step  = rem_next;
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_flags.full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dq   <= n_dq;
        r_rem  <= n_rem;
        r_iter <= n_iter;
        r_home <= n_home;
        r_step <= n_step;
    end

    assign o_busy = (r_state != F_IDLE);
    assign o_job  = '{home: r_home, step: r_step};

endmodule

FILE: sv/dht_queue.sv
`timescale 1ns / 1ps
module dht_queue import dht_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_job     i_job,
    input  logic     i_pop,
    output t_q_flags o_flags,
    output t_job     o_job
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_count, n_count;

    logic do_push;
    logic do_pop;

    always_comb begin
        do_push = i_push && (r_count != QCNT_W'(QUEUE_DEPTH));
        do_pop  = i_pop && (r_count != '0);
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + QCNT_W'(1);
            2'b01:   n_count = r_count - QCNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    assign o_flags.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_flags.empty = (r_count == '0);
    assign o_job         = r_mem[r_rptr];

endmodule

FILE: sv/dht_back.sv
`timescale 1ns / 1ps
module dht_back import dht_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CNT_W-1:0] i_size,
    input  t_q_flags         i_q_flags,
    input  t_job             i_job,
    output logic             o_pop,
    output logic             o_clearing,
    output t_result          o_result
);

    // occupancy store, one bit per slot, registered read
    logic              r_occ [MAX_SLOTS];
    logic              r_occ_rd;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic              mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    t_back_state       r_state, n_state;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic [ADDR_W-1:0] r_home, n_home;
    logic [ADDR_W-1:0] r_step, n_step;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0]  r_probes, n_probes;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [CNT_W-1:0]  r_kcnt, n_kcnt;
    logic              r_valid, n_valid;
    t_status           r_status, n_status;
    logic [ADDR_W-1:0] r_slot, n_slot;
    logic [CNT_W-1:0]  r_pcount, n_pcount;

    logic [SUM_W-1:0]  sum;
    logic [ADDR_W-1:0] pos_next;

    always_comb begin
        sum      = SUM_W'(r_pos) + SUM_W'(r_step);
        pos_next = (sum >= SUM_W'(i_size)) ? ADDR_W'(sum - SUM_W'(i_size)) : ADDR_W'(sum);
    end

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_home    = r_home;
        n_step    = r_step;
        n_pos     = r_pos;
        n_probes  = r_probes;
        n_acc     = r_acc;
        n_kcnt    = r_kcnt;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_slot    = r_slot;
        n_pcount  = r_pcount;
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        mem_wdata = 1'b1;
        mem_raddr = r_pos;
        o_pop     = 1'b0;
        case (r_state)
            B_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = 1'b0;
                n_clr     = r_clr + ADDR_W'(1);
                if (r_clr == ADDR_W'(MAX_SLOTS - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!i_q_flags.empty) begin
                    o_pop  = 1'b1;
                    n_home = i_job.home;
                    n_step = i_job.step;
                    if (r_kcnt >= i_size) begin
                        n_valid  = 1'b1;
                        n_status = ST_FULL;
                        n_slot   = '0;
                        n_pcount = '0;
                    end else begin
                        n_kcnt    = r_kcnt + CNT_W'(1);
                        mem_raddr = i_job.home;
                        n_state   = B_HOME;
                    end
                end
            end
            B_HOME: begin
                if (!r_occ_rd) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_home;
                    n_valid   = 1'b1;
                    n_status  = ST_PLACED;
                    n_slot    = r_home;
                    n_pcount  = CNT_W'(1);
                    n_acc     = r_acc + ACC_W'(1);
                    n_state   = B_IDLE;
                end else begin
                    n_pos    = r_home;
                    n_probes = '0;
                    n_state  = B_STEP;
                end
            end
            B_STEP: begin
                n_probes = r_probes + CNT_W'(1);
                if (pos_next == r_home) begin
                    // walked all the way around: drop
                    n_valid  = 1'b1;
                    n_status = ST_DROPPED;
                    n_slot   = '0;
                    n_pcount = n_probes;
                    n_acc    = r_acc + ACC_W'(n_probes);
                    n_state  = B_IDLE;
                end else begin
                    n_pos     = pos_next;
                    mem_raddr = pos_next;
                    n_state   = B_CHK;
                end
            end
            B_CHK: begin
                if (!r_occ_rd) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pos;
                    n_valid   = 1'b1;
                    n_status  = ST_PLACED;
                    n_slot    = r_pos;
                    n_pcount  = r_probes;
                    n_acc     = r_acc + ACC_W'(r_probes);
                    n_state   = B_IDLE;
                end else begin
                    n_state = B_STEP;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_occ[mem_waddr] <= mem_wdata;
        end
        r_occ_rd <= r_occ[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
            r_clr   <= '0;
            r_acc   <= '0;
            r_kcnt  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_acc   <= n_acc;
            r_kcnt  <= n_kcnt;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_home   <= n_home;
        r_step   <= n_step;
        r_pos    <= n_pos;
        r_probes <= n_probes;
        r_status <= n_status;
        r_slot   <= n_slot;
        r_pcount <= n_pcount;
    end

    assign o_clearing = (r_state == B_CLEAR);
    assign o_result   = '{valid: r_valid, status: r_status, slot: r_slot,
                          probe_count: r_pcount, access_total: r_acc,
                          key_count: r_kcnt};

endmodule

FILE: sv/dht_checker.sv
`timescale 1ns / 1ps
`include "double_hash_table_insert_assert.svh"
module dht_checker import dht_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input logic [1:0]        o_status,
    input logic [ADDR_W-1:0] o_slot,
    input logic [CNT_W-1:0]  o_probe_count,
    input logic [ACC_W-1:0]  o_access_total,
    input logic [CNT_W-1:0]  o_key_count
);

    // a rejected key touches nothing
    `DHT_ASSERT_NOW(a_full_clean, i_clk, i_rst_n, o_valid && (o_status == ST_FULL), (o_slot == '0) && (o_probe_count == '0) && $stable(o_access_total), "full result not clean")

    // an accepted key always costs at least one access and leaves a nonzero key count
    `DHT_ASSERT_NOW(a_taken_counts, i_clk, i_rst_n, o_valid && (o_status != ST_FULL), (o_probe_count != '0) && (o_key_count != '0), "accepted key without access")

    // the running total moves only together with a result
    `DHT_ASSERT_NOW(a_total_with_result, i_clk, i_rst_n, $past(i_rst_n) && !$stable(o_access_total), o_valid, "access total moved without result")

    // the clearing sweep holds off keys right after reset
    `DHT_ASSERT_NOW(a_busy_after_reset, i_clk, i_rst_n, $past(!i_rst_n), busy, "not busy after reset")

    // the divider is engaged on the cycle after a transfer
    `DHT_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, start && !busy, busy, "not busy after transfer")

endmodule

bind double_hash_table_insert dht_checker u_dht_checker (.*);
